// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PTQA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ptqa check failed");

// condition that must never be seen outside reset
`define PTQA_ASSERT_NEVER(label, clk, rst_n, cond) \
    `PTQA_ASSERT(label, clk, rst_n, !(cond))

`endif

// ----- rtl/ptqa_pkg.sv -----
// types and constants of the priority task queue with thread affinity
// no dependencies; imported by every module of the block
package ptqa_pkg;

    // request codes
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DISPATCHED = 2'd0;
    localparam logic [1:0] ST_ADDED      = 2'd1;
    localparam logic [1:0] ST_DROPPED    = 2'd2;
    localparam logic [1:0] ST_NONE       = 2'd3;

    // most tasks handed out by one drain
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // reset value of the thread count register
    localparam logic [6:0] THREAD_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic        req_type;
        logic [15:0] task_handle;
        logic [7:0]  priority_req;
        logic [6:0]  task_affinity;
        logic [5:0]  thread_index;
    } ptqa_req_t;

    typedef struct packed {
        logic [15:0] task_handle_out;
        logic [1:0]  status;
        logic        last;
        logic        queue_empty;
    } ptqa_res_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  prio;
        logic [6:0]  affinity;
    } ptqa_entry_t;

    typedef struct packed {
        logic       shared_mode;
        logic [6:0] thread_count;
    } ptqa_cfg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic add_drop;
        logic add_first;
        logic add_start;
        logic add_shift;
        logic add_place;
        logic add_put_zero;
        logic drain_none;
        logic drain_start;
        logic drain_step;
        logic drain_finish;
    } ptqa_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_full;
        logic is_empty;
        logic shift_more;
        logic ins_at_one;
        logic scan_last;
    } ptqa_stat_t;

endpackage

// ----- rtl/ptqa_regs.sv -----
// configuration registers behind the apb-style port
// depends on ptqa_pkg
module ptqa_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ptqa_pkg::ptqa_cfg_t cfg
);
    import ptqa_pkg::*;

    logic       shared_mode_reg;
    logic [6:0] thread_count_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, word select on address bit two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_mode_reg  <= 1'b0;
            thread_count_reg <= THREAD_COUNT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2])
                thread_count_reg <= pwdata[6:0];
            else
                shared_mode_reg <= pwdata[0];
        end
    end

    // read back
    assign prdata = paddr[2] ? {25'd0, thread_count_reg} : {31'd0, shared_mode_reg};

    assign cfg.shared_mode  = shared_mode_reg;
    assign cfg.thread_count = thread_count_reg;

endmodule

// ----- rtl/ptqa_ctrl.sv -----
// controller state machine sequencing add and drain requests
// depends on ptqa_pkg; drives the datapath by command struct
module ptqa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 req_type,
    input  ptqa_pkg::ptqa_stat_t stat,
    output ptqa_pkg::ptqa_cmd_t  cmd,
    output logic                 busy
);
    import ptqa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_ADD_SCAN   = 5'b00010,
        S_ADD_PUT    = 5'b00100,
        S_DRAIN_SCAN = 5'b01000,
        S_DRAIN_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_ADD)
                    begin
                        if (stat.is_full)
                            cmd.add_drop = 1'b1;
                        else if (stat.is_empty)
                            cmd.add_first = 1'b1;
                        else
                        begin
                            cmd.add_start = 1'b1;
                            state_next    = S_ADD_SCAN;
                        end
                    end
                    else
                    begin
                        if (stat.is_empty)
                            cmd.drain_none = 1'b1;
                        else
                        begin
                            cmd.drain_start = 1'b1;
                            state_next      = S_DRAIN_SCAN;
                        end
                    end
                end
            end
            S_ADD_SCAN:
            begin
                if (stat.shift_more)
                begin
                    cmd.add_shift = 1'b1;
                    if (stat.ins_at_one)
                        state_next = S_ADD_PUT;
                end
                else
                begin
                    cmd.add_place = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ADD_PUT:
            begin
                cmd.add_put_zero = 1'b1;
                state_next       = S_IDLE;
            end
            S_DRAIN_SCAN:
            begin
                cmd.drain_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_DRAIN_DONE;
            end
            S_DRAIN_DONE:
            begin
                cmd.drain_finish = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/ptqa_dpath.sv -----
// datapath: sorted task memory, scan pointers and result register
// depends on ptqa_pkg; commanded by ptqa_ctrl
module ptqa_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptqa_pkg::ptqa_req_t  req,
    input  ptqa_pkg::ptqa_cfg_t  cfg,
    input  ptqa_pkg::ptqa_cmd_t  cmd,
    output ptqa_pkg::ptqa_stat_t stat,
    output logic                 result_valid,
    output ptqa_pkg::ptqa_res_t  result
);
    import ptqa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // task memory, one write and one registered read a cycle
    ptqa_entry_t mem [CAPACITY];
    ptqa_entry_t rd_data_reg;

    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    ptqa_entry_t       wr_data;
    logic [AW-1:0]     rd_addr;

    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     ins_ptr_reg;
    logic [AW-1:0]     scan_idx_reg;
    logic [CW-1:0]     wr_ptr_reg;
    logic [CW-1:0]     remain_reg;
    logic [RES_W-1:0]  n_reg;
    ptqa_entry_t       new_reg;
    logic [5:0]        thr_reg;

    logic              pend_valid_reg;
    logic [15:0]       pend_handle_reg;
    logic              pend_empty_reg;

    logic              res_valid_reg;
    logic              res_valid_next;
    ptqa_res_t         res_reg;
    ptqa_res_t         res_next;

    ptqa_entry_t       req_entry;
    logic [CW-1:0]     count_m1;
    logic              runnable;
    logic              take;

    assign req_entry.handle   = req.task_handle;
    assign req_entry.prio     = req.priority_req;
    assign req_entry.affinity = req.task_affinity;
    assign count_m1           = count_reg - CW'(1);

    // affinity test on the entry being scanned
    assign runnable = cfg.shared_mode
                   || (rd_data_reg.affinity >= cfg.thread_count)
                   || (rd_data_reg.affinity == {1'b0, thr_reg});
    assign take     = cmd.drain_step && runnable && (n_reg < RES_W'(MAX_RESULTS));

    // status to the controller
    assign stat.is_full    = (count_reg >= CW'(CAPACITY));
    assign stat.is_empty   = (count_reg == '0);
    assign stat.shift_more = (rd_data_reg.prio > new_reg.prio);
    assign stat.ins_at_one = (ins_ptr_reg == AW'(1));
    assign stat.scan_last  = (scan_idx_reg == count_m1[AW-1:0]);

    // memory addressing
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        rd_addr = '0;
        if (cmd.add_first)
        begin
            mem_we  = 1'b1;
            wr_data = req_entry;
        end
        if (cmd.add_start)
            rd_addr = count_m1[AW-1:0];
        if (cmd.add_shift)
        begin
            mem_we  = 1'b1;
            wr_addr = ins_ptr_reg;
            rd_addr = ins_ptr_reg - AW'(2);
        end
        if (cmd.add_place)
        begin
            mem_we  = 1'b1;
            wr_addr = ins_ptr_reg;
            wr_data = new_reg;
        end
        if (cmd.add_put_zero)
        begin
            mem_we  = 1'b1;
            wr_data = new_reg;
        end
        if (cmd.drain_step)
        begin
            rd_addr = scan_idx_reg + AW'(1);
            if (!take)
            begin
                mem_we  = 1'b1;
                wr_addr = wr_ptr_reg[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // result selection
    always_comb
    begin
        res_valid_next           = 1'b0;
        res_next.task_handle_out = '0;
        res_next.status          = ST_ADDED;
        res_next.last            = 1'b1;
        res_next.queue_empty     = 1'b0;
        if (cmd.add_drop)
        begin
            res_valid_next       = 1'b1;
            res_next.status      = ST_DROPPED;
            res_next.queue_empty = (count_reg == '0);
        end
        if (cmd.add_first || cmd.add_place || cmd.add_put_zero)
            res_valid_next = 1'b1;
        if (cmd.drain_none)
        begin
            res_valid_next       = 1'b1;
            res_next.status      = ST_NONE;
            res_next.queue_empty = 1'b1;
        end
        if (take && pend_valid_reg)
        begin
            res_valid_next           = 1'b1;
            res_next.task_handle_out = pend_handle_reg;
            res_next.status          = ST_DISPATCHED;
            res_next.last            = 1'b0;
            res_next.queue_empty     = pend_empty_reg;
        end
        if (cmd.drain_finish)
        begin
            res_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                res_next.task_handle_out = pend_handle_reg;
                res_next.status          = ST_DISPATCHED;
                res_next.queue_empty     = pend_empty_reg;
            end
            else
            begin
                res_next.status      = ST_NONE;
                res_next.queue_empty = (wr_ptr_reg == '0);
            end
        end
    end

    // control counters and pending dispatch flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ins_ptr_reg    <= '0;
            scan_idx_reg   <= '0;
            wr_ptr_reg     <= '0;
            remain_reg     <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd.add_first || cmd.add_place || cmd.add_put_zero)
                count_reg <= count_reg + CW'(1);
            if (cmd.drain_finish)
                count_reg <= wr_ptr_reg;
            if (cmd.add_start)
                ins_ptr_reg <= count_reg[AW-1:0];
            if (cmd.add_shift)
                ins_ptr_reg <= ins_ptr_reg - AW'(1);
            if (cmd.drain_start)
            begin
                scan_idx_reg   <= '0;
                wr_ptr_reg     <= '0;
                remain_reg     <= count_reg;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.drain_step)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
                if (take)
                begin
                    remain_reg     <= remain_reg - CW'(1);
                    n_reg          <= n_reg + RES_W'(1);
                    pend_valid_reg <= 1'b1;
                end
                else
                    wr_ptr_reg <= wr_ptr_reg + CW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.add_start || cmd.drain_start)
        begin
            new_reg <= req_entry;
            thr_reg <= req.thread_index;
        end
        if (take)
        begin
            pend_handle_reg <= rd_data_reg.handle;
            pend_empty_reg  <= (remain_reg == CW'(1));
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/priority_task_queue_with_affinity.sv -----
// top level of the priority task queue with thread affinity
// depends on ptqa_pkg, ptqa_regs, ptqa_ctrl and ptqa_dpath
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------
//  request   | start, busy             | req (ptqa_req_t)
//  result    | result_valid (strobe)   | result (ptqa_res_t)
//  config    | psel, penable, pwrite   | paddr, pwdata, prdata
//
// a request transfers when start is high and busy low. an add to a full or empty
// queue is answered from the idle state; else it moves one stored entry per cycle
// until it finds its place. a drain visits the stored entries through the single
// read port of the task memory, one entry per cycle. each result is strobed for a
// single cycle and cannot be stalled; the final result shows as busy falls.
// reset is asynchronous and active low; the task memory needs no clearing.
module priority_task_queue_with_affinity #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ptqa_pkg::ptqa_req_t req,
    output logic                result_valid,
    output ptqa_pkg::ptqa_res_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ptqa_pkg::*;

    ptqa_cfg_t  cfg;
    ptqa_cmd_t  cmd;
    ptqa_stat_t stat;

    // configuration registers
    ptqa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing
    ptqa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // storage and results
    ptqa_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- rtl/ptqa_checker.sv -----
// port-level checks of the task queue, bound to the top level
// depends on ptqa_pkg and assert_macros.svh
`include "assert_macros.svh"

module ptqa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input ptqa_pkg::ptqa_res_t result
);
    import ptqa_pkg::*;

    // an accepted request is either answered at once or keeps the block busy
    `PTQA_ASSERT(a_accept_progress, clk, rst_n, (start && !busy) |=> (busy || result_valid))

    // add results and empty drains are always the final transfer
    `PTQA_ASSERT(a_single_last, clk, rst_n, (result_valid && result.status != ST_DISPATCHED) |-> result.last)

    // only dispatches carry a handle
    `PTQA_ASSERT(a_handle_zero, clk, rst_n, (result_valid && result.status != ST_DISPATCHED) |-> (result.task_handle_out == 16'd0))

    // the final transfer is shown as busy is released, earlier ones while busy
    `PTQA_ASSERT(a_last_idle, clk, rst_n, (result_valid && result.last) |-> !busy)
    `PTQA_ASSERT_NEVER(a_mid_idle, clk, rst_n, result_valid && !result.last && !busy)

endmodule

bind priority_task_queue_with_affinity ptqa_checker u_ptqa_checker (.*);

// ----- tb/sv/priority_task_queue_with_affinity_tb.sv -----
// self-checking testbench of the priority task queue with thread affinity
// directed table then randomised phases, every result checked against a local dispatch predictor or a table value
// depends on ptqa_pkg and priority_task_queue_with_affinity
`timescale 1ns / 1ps

module priority_task_queue_with_affinity_tb;

    import ptqa_pkg::*;

    localparam int CAPACITY = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 34;

    // register byte addresses
    localparam logic [2:0] ADDR_SHARED_MODE  = 3'd0;
    localparam logic [2:0] ADDR_THREAD_COUNT = 3'd4;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t   kind;
        ptqa_req_t   req;
        int unsigned reps;
        logic        typed;
        ptqa_res_t   want;
        logic [2:0]  addr;
        logic [31:0] data;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    ptqa_req_t   req_bus = '0;
    logic        result_valid;
    ptqa_res_t   result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    ptqa_entry_t stored_tasks[$];
    logic        model_shared = 1'b0;
    logic [6:0]  model_threads = THREAD_COUNT_RESET;
    ptqa_res_t   fresh_results[$];
    ptqa_res_t   pending_results[$];

    plan_row_t   directed_plan[$];
    int unsigned mismatches = 0;
    int unsigned stalled_cycles = 0;
    bit          steady = 1'b0;

    priority_task_queue_with_affinity #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req_bus),
        .result_valid(result_valid),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // dispatch predictor: fills fresh_results with what one request gives
    function automatic void predict_dispatch(input ptqa_req_t r);
        ptqa_entry_t e;
        ptqa_entry_t kept[$];
        int          pos;
        int          n;
        int          remaining;
        bit          runnable;
        fresh_results.delete();
        if (r.req_type == REQ_ADD)
        begin
            if (stored_tasks.size() >= CAPACITY)
            begin
                fresh_results.insert(fresh_results.size(),
                                     ptqa_res_t'{16'h0000, ST_DROPPED, 1'b1,
                                                 stored_tasks.size() == 0});
            end
            else
            begin
                // after every entry of equal or smaller priority
                pos = stored_tasks.size();
                while (pos > 0 && stored_tasks[pos - 1].prio > r.priority_req)
                    pos--;
                e.handle   = r.task_handle;
                e.prio     = r.priority_req;
                e.affinity = r.task_affinity;
                stored_tasks.insert(pos, e);
                fresh_results.insert(fresh_results.size(),
                                     ptqa_res_t'{16'h0000, ST_ADDED, 1'b1, 1'b0});
            end
        end
        else
        begin
            n = 0;
            remaining = stored_tasks.size();
            foreach (stored_tasks[i])
            begin
                e = stored_tasks[i];
                runnable = model_shared || (e.affinity >= model_threads) ||
                           (e.affinity == {1'b0, r.thread_index});
                if (runnable && n < MAX_RESULTS)
                begin
                    remaining--;
                    fresh_results.insert(fresh_results.size(),
                                         ptqa_res_t'{e.handle, ST_DISPATCHED, 1'b0,
                                                     remaining == 0});
                    n++;
                end
                else
                begin
                    kept.insert(kept.size(), e);
                end
            end
            stored_tasks = kept;
            if (n == 0)
                fresh_results.insert(fresh_results.size(),
                                     ptqa_res_t'{16'h0000, ST_NONE, 1'b1,
                                                 stored_tasks.size() == 0});
            else
                fresh_results[$].last = 1'b1;
        end
    endfunction

    function automatic plan_row_t req_row(input logic rt, input logic [15:0] h,
                                          input logic [7:0] p, input logic [6:0] a,
                                          input logic [5:0] t, input int unsigned reps,
                                          input logic typed, input ptqa_res_t want);
        plan_row_t row;
        row.kind  = ROW_REQ;
        row.req   = ptqa_req_t'{rt, h, p, a, t};
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        row.addr  = '0;
        row.data  = '0;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [2:0] a, input logic [31:0] d);
        plan_row_t row;
        row.kind  = ROW_CFG;
        row.req   = '0;
        row.reps  = 0;
        row.typed = 1'b0;
        row.want  = '0;
        row.addr  = a;
        row.data  = d;
        return row;
    endfunction

    // append one line to the directed table
    function automatic void plan_add(input plan_row_t row);
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    // random request biased towards affinities and threads that meet
    function automatic ptqa_req_t random_request(input logic [6:0] tc,
                                                 input int unsigned add_pct);
        ptqa_req_t   r;
        int unsigned lim;
        lim = (tc == 0) ? 1 : tc + 1;
        if (lim > 127)
            lim = 127;
        r.req_type      = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_DRAIN;
        r.task_handle   = 16'($urandom());
        r.priority_req  = ($urandom_range(2) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
        r.task_affinity = ($urandom_range(3) == 0) ? 7'($urandom()) : 7'($urandom_range(lim));
        r.thread_index  = ($urandom_range(3) == 0) ? 6'($urandom()) :
                          6'($urandom_range((lim > 63) ? 63 : lim));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // sender idles at random unless in the steady stretch
    task automatic idle_gap();
        if (!steady)
        begin
            while ($urandom_range(99) < 34)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // one request transfer, then its expected results are queued
    task automatic issue(input ptqa_req_t r, input logic typed, input ptqa_res_t want);
        start   <= 1'b1;
        req_bus <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_dispatch(r);
        if (typed)
            pending_results.insert(pending_results.size(), want);
        else
            foreach (fresh_results[i])
                pending_results.insert(pending_results.size(), fresh_results[i]);
    endtask

    // wait until every expected result has arrived and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // register write: setup then access cycle
    task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == ADDR_SHARED_MODE)
            model_shared = d[0];
        else if (a == ADDR_THREAD_COUNT)
            model_threads = d[6:0];
        @(posedge clk);
    endtask

    // result checking against the oldest expectation
    always @(posedge clk)
    begin : result_check
        ptqa_res_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", result.task_handle_out, 16'h0000);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.task_handle_out !== want.task_handle_out)
                    report_mismatch("task_handle_out", result.task_handle_out,
                                    want.task_handle_out);
                if (result.status !== want.status)
                    report_mismatch("status", 16'(result.status), 16'(want.status));
                if (result.last !== want.last)
                    report_mismatch("last", 16'(result.last), 16'(want.last));
                if (result.queue_empty !== want.queue_empty)
                    report_mismatch("queue_empty", 16'(result.queue_empty),
                                    16'(want.queue_empty));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles == STALL_LIMIT)
        begin
            $display("priority_task_queue_with_affinity_tb: done, errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        plan_row_t   row;
        ptqa_req_t   r;
        int unsigned k;
        int unsigned ph;
        int unsigned add_pct;
        logic        shared;
        logic [6:0]  tc;

        // empty store, extremes of the fields, equal priorities
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd0, 1, 1'b1,
                         ptqa_res_t'{16'h0000, ST_NONE, 1'b1, 1'b1}));
        plan_add(req_row(REQ_ADD, 16'h0000, 8'h00, 7'h00, 6'd0, 1, 1'b1,
                         ptqa_res_t'{16'h0000, ST_ADDED, 1'b1, 1'b0}));
        plan_add(req_row(REQ_ADD, 16'hffff, 8'hff, 7'h7f, 6'd63, 1, 1'b1,
                         ptqa_res_t'{16'h0000, ST_ADDED, 1'b1, 1'b0}));
        plan_add(req_row(REQ_ADD, 16'h1234, 8'h80, 7'd3, 6'd0, 1, 1'b0, '0));
        plan_add(req_row(REQ_ADD, 16'h0005, 8'h80, 7'd63, 6'd0, 1, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'hffff, 8'hff, 7'h7f, 6'd63, 1, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd5, 1, 1'b0, '0));
        // fill to capacity, then the add that gets dropped
        plan_add(req_row(REQ_ADD, 16'h0100, 8'h10, 7'd0, 6'd0, 14, 1'b0, '0));
        plan_add(req_row(REQ_ADD, 16'h4321, 8'h00, 7'd1, 6'd0, 1, 1'b1,
                         ptqa_res_t'{16'h0000, ST_DROPPED, 1'b1, 1'b0}));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd0, 1, 1'b0, '0));
        // shared mode: everything runnable, full drain of capacity entries
        plan_add(cfg_row(ADDR_SHARED_MODE, 32'd1));
        plan_add(req_row(REQ_ADD, 16'hbeef, 8'hff, 7'h7f, 6'd0, 1, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd17, 1, 1'b0, '0));
        plan_add(req_row(REQ_ADD, 16'h0300, 8'hf0, 7'd9, 6'd0, 16, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd0, 1, 1'b0, '0));
        // thread count zero: every affinity means any thread
        plan_add(cfg_row(ADDR_SHARED_MODE, 32'd0));
        plan_add(cfg_row(ADDR_THREAD_COUNT, 32'd0));
        plan_add(req_row(REQ_ADD, 16'haaaa, 8'h55, 7'h2a, 6'h15, 1, 1'b0, '0));
        plan_add(req_row(REQ_ADD, 16'h5555, 8'haa, 7'h55, 6'h2a, 1, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'h2a, 1, 1'b0, '0));
        // smallest and largest thread counts
        plan_add(cfg_row(ADDR_THREAD_COUNT, 32'd1));
        plan_add(req_row(REQ_ADD, 16'h0200, 8'hfe, 7'd0, 6'd0, 4, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd0, 1, 1'b0, '0));
        plan_add(cfg_row(ADDR_THREAD_COUNT, 32'd127));
        plan_add(req_row(REQ_ADD, 16'h7777, 8'h00, 7'd126, 6'd0, 1, 1'b0, '0));
        plan_add(req_row(REQ_DRAIN, 16'h0000, 8'h00, 7'h00, 6'd1, 1, 1'b0, '0));

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(row.addr, row.data);
            end
            else
            begin
                for (k = 0; k < row.reps; k++)
                begin
                    r = row.req;
                    r.task_handle   = r.task_handle + 16'(k);
                    r.priority_req  = r.priority_req + 8'(k * 29);
                    r.task_affinity = r.task_affinity + 7'(k);
                    idle_gap();
                    issue(r, row.typed && row.reps == 1, row.want);
                end
            end
        end

        // random phases, each under its own register settings
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: tc = 7'd1;
                1: tc = 7'd64;
                2: tc = 7'd127;
                3: tc = 7'd0;
                default: tc = $urandom_range(1) ? 7'($urandom_range(1, 8)) :
                                                  7'($urandom_range(1, 64));
            endcase
            shared = (ph == 5) || ($urandom_range(4) == 0);
            write_reg(ADDR_SHARED_MODE, {31'd0, shared});
            write_reg(ADDR_THREAD_COUNT, {25'd0, tc});
            add_pct = $urandom_range(45, 80);
            steady = (ph == 4);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r = random_request(tc, add_pct);
                idle_gap();
                issue(r, 1'b0, '0);
            end
        end

        // drain out and let the block settle
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("priority_task_queue_with_affinity_tb: done, clean");
        else
            $display("priority_task_queue_with_affinity_tb: done, errors");
        $finish;
    end

endmodule
